FILE: hdl/vendor_command_framer_macros.svh
// Assertion macros used by the port-level checker of the command framer.
`ifndef VENDOR_COMMAND_FRAMER_MACROS_SVH
`define VENDOR_COMMAND_FRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define VCF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framer check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define VCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

FILE: hdl/vcf_pkg.sv
// Package with the constants and the state type of the command framer.
`default_nettype none
package vcf_pkg;

  localparam int unsigned HEADER_BYTES = 8;
  localparam logic [7:0]  TYPE_BYTE    = 8'h91;

  // Header positions that the framer looks at.
  localparam int unsigned POS_TYPE   = 1;
  localparam int unsigned POS_LEN_HI = 4;
  localparam int unsigned POS_LEN_LO = 5;

  localparam logic KIND_COMMAND = 1'b0;
  localparam logic KIND_REJECT  = 1'b1;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_READ,
    ST_LOAD
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/vendor_command_framer.sv
// Top level of the vendor command framer: byte gathering, buffer and output.
`default_nettype none
// Takes one byte per request and frames 8-byte headers (type byte 0x91 at
// position 1, big-endian payload length at positions 4 and 5). A header
// with a bad type byte, or one whose command would exceed MAX_COMMAND_BYTES,
// yields a single reject notice and, in the too-long case, the following
// payload bytes are swallowed silently. A complete command sits in a
// one-port-write, one-port-read buffer memory and is then replayed byte by
// byte (buffer read, then output register load), and the replay waits on any
// stall on the output side; no byte is accepted during the replay.
// reject_total shows the wrapping 32-bit count of rejected headers.
module vendor_command_framer #(
  parameter int unsigned MAX_COMMAND_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [7:0]       out_byte,
  output logic [5:0]       out_index,
  output logic             is_last,
  output logic [31:0]      reject_total
);

  localparam int unsigned AW = $clog2(MAX_COMMAND_BYTES);
  localparam int unsigned CW = $clog2(MAX_COMMAND_BYTES + 1);

  vcf_pkg::state_t state, state_next;

  logic [7:0]    frame_buffer [MAX_COMMAND_BYTES];
  logic [7:0]    rd_data;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] expected_length;
  logic [15:0]   skip_remaining;
  logic [31:0]   reject_counter;
  logic [AW-1:0] rd_idx;
  logic [7:0]    hdr_type;
  logic [7:0]    len_hi;
  logic [7:0]    len_lo;

  logic          rd_en;
  logic          load_cmd;
  logic          accept;
  logic          wr_en;
  logic          hdr_done;
  logic          type_ok;
  logic [16:0]   total;
  logic          reject;
  logic          frame_done;
  logic          rd_last;

  // Control outputs of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    load_cmd = 1'b0;
    unique case (state)
      vcf_pkg::ST_RECV: in_ready = !out_valid || out_ready;
      vcf_pkg::ST_READ: rd_en = 1'b1;
      vcf_pkg::ST_LOAD: load_cmd = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    accept   = in_valid && in_ready;
    wr_en    = accept && (skip_remaining == 16'd0);
    hdr_done = wr_en && (expected_length == '0)
               && (fill_count == CW'(vcf_pkg::HEADER_BYTES - 1));
    type_ok  = (hdr_type == vcf_pkg::TYPE_BYTE);
    total    = 17'(vcf_pkg::HEADER_BYTES) + {1'b0, len_hi, len_lo};
    reject   = hdr_done && (!type_ok || (total > 17'(MAX_COMMAND_BYTES)));
    frame_done = wr_en && !reject
                 && ((hdr_done && (total == 17'(vcf_pkg::HEADER_BYTES)))
                     || ((expected_length != '0)
                         && (fill_count + CW'(1) == expected_length)));
    rd_last  = (CW'(rd_idx) + CW'(1) == expected_length);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      vcf_pkg::ST_RECV: if (frame_done) state_next = vcf_pkg::ST_READ;
      vcf_pkg::ST_READ: state_next = vcf_pkg::ST_LOAD;
      vcf_pkg::ST_LOAD: begin
        if (load_cmd) state_next = rd_last ? vcf_pkg::ST_RECV : vcf_pkg::ST_READ;
      end
      default: state_next = vcf_pkg::ST_RECV;
    endcase
  end

  // Buffer memory: written while bytes arrive, read during the replay.
  always_ff @(posedge clk) begin
    if (wr_en) frame_buffer[fill_count[AW-1:0]] <= data_byte;
    if (rd_en) rd_data <= frame_buffer[rd_idx];
  end

  // Header fields are captured on their way into the buffer.
  always_ff @(posedge clk) begin
    if (wr_en && (expected_length == '0)) begin
      if (fill_count == CW'(vcf_pkg::POS_TYPE))   hdr_type <= data_byte;
      if (fill_count == CW'(vcf_pkg::POS_LEN_HI)) len_hi   <= data_byte;
      if (fill_count == CW'(vcf_pkg::POS_LEN_LO)) len_lo   <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= vcf_pkg::ST_RECV;
      fill_count      <= '0;
      expected_length <= '0;
      skip_remaining  <= '0;
      reject_counter  <= '0;
      rd_idx          <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (skip_remaining != 16'd0)) begin
        skip_remaining <= skip_remaining - 16'd1;
      end
      if (reject) begin
        reject_counter <= reject_counter + 32'd1;
        if (type_ok) skip_remaining <= {len_hi, len_lo};
        fill_count      <= '0;
        expected_length <= '0;
      end else if (frame_done) begin
        fill_count <= '0;
        rd_idx     <= '0;
        if (hdr_done) expected_length <= CW'(total);
      end else if (wr_en) begin
        fill_count <= fill_count + CW'(1);
        if (hdr_done) expected_length <= CW'(total);
      end
      if (load_cmd) begin
        out_valid <= 1'b1;
        if (rd_last) begin
          expected_length <= '0;
        end else begin
          rd_idx <= rd_idx + AW'(1);
        end
      end else if (reject) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; a notice and a buffered byte never load in one cycle.
  always_ff @(posedge clk) begin
    if (load_cmd) begin
      out_kind  <= vcf_pkg::KIND_COMMAND;
      out_byte  <= rd_data;
      out_index <= 6'(rd_idx);
      is_last   <= rd_last;
    end else if (reject) begin
      out_kind  <= vcf_pkg::KIND_REJECT;
      out_byte  <= 8'd0;
      out_index <= 6'd0;
      is_last   <= 1'b1;
    end
  end

  assign reject_total = reject_counter;

endmodule
`default_nettype wire

FILE: hdl/vcf_checker.sv
// Port-level checker for the command framer and its bind.
`default_nettype none
`include "vendor_command_framer_macros.svh"
module vcf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_kind,
  input wire logic [7:0]  out_byte,
  input wire logic [5:0]  out_index,
  input wire logic        is_last,
  input wire logic [31:0] reject_total
);

  // A reject notice carries no byte and closes itself.
  `VCF_ASSERT_NOW(a_notice_shape, out_valid && out_kind, is_last && out_byte == 8'd0 && out_index == 6'd0)

  // Every command is at least a full header long.
  `VCF_ASSERT_NOW(a_cmd_min_len, out_valid && !out_kind && is_last, out_index >= 6'd7)

  // The reject count moves only when a byte has been taken.
  `VCF_ASSERT_NEXT(a_count_idle, !(in_valid && in_ready), $stable(reject_total))

  // A stalled result holds.
  `VCF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_index) && $stable(out_kind))

endmodule

bind vendor_command_framer vcf_checker u_vcf_checker (.*);
`default_nettype wire

FILE: tb/sv/framer_checker.sv
// Checker for the command framer: predicts the results of each request and compares them.
module framer_checker #(
  parameter int unsigned MAX_COMMAND_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_kind,
  input  logic [7:0]  out_byte,
  input  logic [5:0]  out_index,
  input  logic        is_last,
  input  logic [31:0] reject_total,
  output int          mismatches,
  output int          results_due
);

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [5:0]  pos;
    logic        last_flag;
    logic [31:0] total;
  } framer_result_t;

  framer_result_t due_q[$];

  // Shadow of the framer state.
  logic [7:0]  shadow_buf [64];
  logic [6:0]  fill_cnt;
  logic [6:0]  cmd_len;
  logic [15:0] skip_cnt;
  logic [31:0] reject_cnt;

  initial begin
    mismatches  = 0;
    results_due = 0;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch: %s got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    logic [15:0]    payload;
    int unsigned    total;
    logic           type_ok;
    framer_result_t r;
    if (skip_cnt != 0) begin
      skip_cnt--;
      return;
    end
    shadow_buf[fill_cnt[5:0]] = b;
    fill_cnt++;
    if (cmd_len == 0 && fill_cnt == vcf_pkg::HEADER_BYTES) begin
      payload = {shadow_buf[vcf_pkg::POS_LEN_HI], shadow_buf[vcf_pkg::POS_LEN_LO]};
      total   = vcf_pkg::HEADER_BYTES + payload;
      type_ok = (shadow_buf[vcf_pkg::POS_TYPE] == vcf_pkg::TYPE_BYTE);
      if (!type_ok || total > MAX_COMMAND_BYTES) begin
        reject_cnt++;
        // Only an oversized command of the right type has its payload swallowed.
        if (type_ok) begin
          skip_cnt = payload;
        end
        fill_cnt    = '0;
        cmd_len     = '0;
        r.kind      = vcf_pkg::KIND_REJECT;
        r.data      = 8'h00;
        r.pos       = 6'd0;
        r.last_flag = 1'b1;
        r.total     = reject_cnt;
        due_q.push_back(r);
        return;
      end
      cmd_len = total[6:0];
    end
    if (cmd_len != 0 && fill_cnt == cmd_len) begin
      for (int i = 0; i < cmd_len; i++) begin
        r.kind      = vcf_pkg::KIND_COMMAND;
        r.data      = shadow_buf[i];
        r.pos       = i[5:0];
        r.last_flag = (i + 1 == cmd_len);
        r.total     = reject_cnt;
        due_q.push_back(r);
      end
      fill_cnt = '0;
      cmd_len  = '0;
    end
  endtask

  task automatic check_result();
    framer_result_t w;
    if (due_q.size() == 0) begin
      flag_mismatch("result with nothing due, out_byte", {24'h0, out_byte}, 32'h0);
      return;
    end
    w = due_q.pop_front();
    if (out_kind !== w.kind) flag_mismatch("out_kind", {31'h0, out_kind}, {31'h0, w.kind});
    if (out_byte !== w.data) flag_mismatch("out_byte", {24'h0, out_byte}, {24'h0, w.data});
    if (out_index !== w.pos) flag_mismatch("out_index", {26'h0, out_index}, {26'h0, w.pos});
    if (is_last !== w.last_flag) begin
      flag_mismatch("is_last", {31'h0, is_last}, {31'h0, w.last_flag});
    end
    if (reject_total !== w.total) flag_mismatch("reject_total", reject_total, w.total);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_q.delete();
      fill_cnt   = '0;
      cmd_len    = '0;
      skip_cnt   = '0;
      reject_cnt = '0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) absorb_byte(data_byte);
    end
    results_due <= due_q.size();
  end

endmodule

FILE: tb/sv/tb.sv
// Testbench top of the command framer: clock, reset, byte stream, output stalls, verdict.
module tb;

  localparam int unsigned MAX_BYTES    = 64;
  localparam int unsigned MAX_PAYLOAD  = MAX_BYTES - vcf_pkg::HEADER_BYTES;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned CALM_AFTER   = 300;
  localparam int unsigned HOLD_AFTER   = 200;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic [5:0]  out_index;
  logic        is_last;
  logic [31:0] reject_total;

  int          mismatches;
  int          results_due;
  int unsigned idle_cycles = 0;
  int unsigned random_sent = 0;
  bit          calm        = 1'b0;
  bit          hold_req    = 1'b0;
  bit          hold_armed  = 1'b0;

  vendor_command_framer #(.MAX_COMMAND_BYTES(MAX_BYTES)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_index    (out_index),
    .is_last      (is_last),
    .reject_total (reject_total)
  );

  framer_checker #(.MAX_COMMAND_BYTES(MAX_BYTES)) frame_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_index    (out_index),
    .is_last      (is_last),
    .reject_total (reject_total),
    .mismatches   (mismatches),
    .results_due  (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Ends the run when neither channel has moved for too long.
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Output side: random stall bursts, plus one long hold-off to back the block up.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] wrong_type();
    logic [7:0] v;
    if ($urandom_range(0, 1) == 0) begin
      v = vcf_pkg::TYPE_BYTE ^ (8'h01 << $urandom_range(0, 7));
    end else begin
      v = 8'($urandom_range(0, 255));
      if (v == vcf_pkg::TYPE_BYTE) v = ~v;
    end
    return v;
  endfunction

  // Offers one byte, possibly after an idle burst, and returns at the edge it is taken.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    random_sent++;
  endtask

  task automatic send_header(input logic [7:0] kind_byte, input logic [15:0] len,
                             input bit pad_rand, input logic [7:0] pad);
    logic [7:0] v;
    for (int i = 0; i < vcf_pkg::HEADER_BYTES; i++) begin
      v = pad_rand ? 8'($urandom_range(0, 255)) : pad;
      if (i == vcf_pkg::POS_TYPE) v = kind_byte;
      else if (i == vcf_pkg::POS_LEN_HI) v = len[15:8];
      else if (i == vcf_pkg::POS_LEN_LO) v = len[7:0];
      send_byte(v);
    end
  endtask

  task automatic send_command(input int unsigned plen);
    send_header(vcf_pkg::TYPE_BYTE, plen[15:0], 1'b1, 8'h00);
    repeat (plen) begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // An oversized command of the right type; its payload is swallowed by the block.
  task automatic send_too_long(input int unsigned plen);
    send_header(vcf_pkg::TYPE_BYTE, plen[15:0], 1'b1, 8'h00);
    repeat (plen) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned pick;
    int unsigned plen;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extremes of the header fields and each kind of header.
    send_header(vcf_pkg::TYPE_BYTE, 16'h0000, 1'b0, 8'hFF);
    send_header(vcf_pkg::TYPE_BYTE, 16'h0001, 1'b0, 8'h00);
    send_byte(8'hFF);
    send_command(MAX_PAYLOAD);
    send_too_long(MAX_PAYLOAD + 1);
    send_header(8'h90, 16'h0000, 1'b0, 8'h00);
    send_header(8'h00, 16'hFFFF, 1'b0, 8'hFF);
    send_header(8'hFF, 16'h0000, 1'b1, 8'h00);
    send_command(0);
    send_command(3);

    // Random part: mostly well-formed commands, the rest rejected headers.
    while (random_sent < RANDOM_ITEMS) begin
      calm = (random_sent >= CALM_AFTER);
      if (!hold_armed && random_sent >= HOLD_AFTER) begin
        hold_armed = 1'b1;
        hold_req   = 1'b1;
      end
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        if ($urandom_range(0, 9) == 0) plen = $urandom_range(0, MAX_PAYLOAD);
        else plen = $urandom_range(0, 8);
        send_command(plen);
      end else if (pick < 16) begin
        send_header(wrong_type(), 16'($urandom_range(0, 65535)), 1'b1, 8'h00);
      end else if (pick < 18) begin
        send_too_long($urandom_range(MAX_PAYLOAD + 1, MAX_PAYLOAD + 30));
      end else begin
        repeat ($urandom_range(2, 4)) begin
          send_header(wrong_type(), 16'($urandom_range(0, 65535)), 1'b1, 8'h00);
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/vcf_pkg.sv
hdl/vendor_command_framer.sv
hdl/vcf_checker.sv
tb/sv/framer_checker.sv
tb/sv/tb.sv
